/* rtl/core/sit_pkg.sv */
// Package for the segment intersection test pipeline.
// Holds the default coordinate width, the output bus width and the result type.
// No dependencies.
package sit_pkg;

  // Default coordinate width of one endpoint field.
  localparam int COORD_WIDTH_DEF = 16;

  // Result bus: two flags, padded up to one byte.
  localparam int RESULT_TDATA_W = 8;

  // Flags of one result item.
  typedef struct packed {
    logic parallel;
    logic intersects;
  } sit_result_t;

endpackage

/* rtl/core/segment_intersection_test.sv */
// Top level of the segment intersection test: four-stage pipeline built from
// sit_diff, sit_mult, sit_comb and sit_cmp. Depends on sit_pkg.
//
//   Channel    Direction  Transfer when                 Contents
//   s_axis_*   in         s_axis_tvalid & s_axis_tready  eight endpoint coordinates
//   m_axis_*   out        m_axis_tvalid & m_axis_tready  intersects and parallel flags
//
// Each input transfer moves through the difference, product, combine and compare registers
// in turn; the compare register drives m_axis. One segment pair is accepted every cycle while m_axis
// does not stall; the registered multiplier stage holds six independent multipliers.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A stall on m_axis holds every occupied stage; empty stages still fill, so
// the block keeps taking input until all four stages are occupied.
module segment_intersection_test
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // From bit 0: seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
  // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (COORD_WIDTH each).
  input  logic [8*COORD_WIDTH-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // From bit 0: intersects, parallel, then zero padding.
  output logic [RESULT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic              v1, v2, v3;
  logic              r1, r2, r3;
  logic signed [DW-1:0] dx12, dy12, dx34, dy34, dx13, dy13;
  logic signed [PW-1:0] p_d0, p_d1, p_t0, p_t1, p_u0, p_u1;
  logic signed [SW-1:0] d, tn, un;
  sit_result_t       result;

  // Stage 1: coordinate differences.
  sit_diff #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_diff (
    .clk      (clk),
    .rst      (rst),
    .valid_in (s_axis_tvalid),
    .ready_up (s_axis_tready),
    .coords   (s_axis_tdata),
    .valid    (v1),
    .ready_dn (r1),
    .dx12     (dx12),
    .dy12     (dy12),
    .dx34     (dx34),
    .dy34     (dy34),
    .dx13     (dx13),
    .dy13     (dy13)
  );

  // Stage 2: cross-product terms.
  sit_mult #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mult (
    .clk      (clk),
    .rst      (rst),
    .valid_in (v1),
    .ready_up (r1),
    .dx12     (dx12),
    .dy12     (dy12),
    .dx34     (dx34),
    .dy34     (dy34),
    .dx13     (dx13),
    .dy13     (dy13),
    .valid    (v2),
    .ready_dn (r2),
    .p_d0     (p_d0),
    .p_d1     (p_d1),
    .p_t0     (p_t0),
    .p_t1     (p_t1),
    .p_u0     (p_u0),
    .p_u1     (p_u1)
  );

  // Stage 3: d, tn and un.
  sit_comb #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_comb (
    .clk      (clk),
    .rst      (rst),
    .valid_in (v2),
    .ready_up (r2),
    .p_d0     (p_d0),
    .p_d1     (p_d1),
    .p_t0     (p_t0),
    .p_t1     (p_t1),
    .p_u0     (p_u0),
    .p_u1     (p_u1),
    .valid    (v3),
    .ready_dn (r3),
    .d        (d),
    .tn       (tn),
    .un       (un)
  );

  // Stage 4: range tests into the output register.
  sit_cmp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cmp (
    .clk      (clk),
    .rst      (rst),
    .valid_in (v3),
    .ready_up (r3),
    .d        (d),
    .tn       (tn),
    .un       (un),
    .valid    (m_axis_tvalid),
    .ready_dn (m_axis_tready),
    .result   (result)
  );

  // Pack the flags into the low bits of the result bus.
  assign m_axis_tdata = {{(RESULT_TDATA_W - 2){1'b0}}, result.parallel, result.intersects};

endmodule

/* rtl/core/sit_diff.sv */
// First pipeline stage: coordinate differences of the two segments.
// Depends on sit_pkg.
module sit_diff
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid_in,
  output logic                                ready_up,
  input  logic [8*COORD_WIDTH-1:0]            coords,
  output logic                                valid,
  input  logic                                ready_dn,
  output logic signed [COORD_WIDTH:0]         dx12,
  output logic signed [COORD_WIDTH:0]         dy12,
  output logic signed [COORD_WIDTH:0]         dx34,
  output logic signed [COORD_WIDTH:0]         dy34,
  output logic signed [COORD_WIDTH:0]         dx13,
  output logic signed [COORD_WIDTH:0]         dy13
);

  localparam int CW = COORD_WIDTH;

  logic signed [CW:0] x1, y1, x2, y2, x3, y3, x4;
  logic signed [CW:0] y4;

  // Sign-extend each field by one bit so the differences cannot overflow.
  assign x1 = $signed({coords[1*CW-1], coords[1*CW-1:0*CW]});
  assign y1 = $signed({coords[2*CW-1], coords[2*CW-1:1*CW]});
  assign x2 = $signed({coords[3*CW-1], coords[3*CW-1:2*CW]});
  assign y2 = $signed({coords[4*CW-1], coords[4*CW-1:3*CW]});
  assign x3 = $signed({coords[5*CW-1], coords[5*CW-1:4*CW]});
  assign y3 = $signed({coords[6*CW-1], coords[6*CW-1:5*CW]});
  assign x4 = $signed({coords[7*CW-1], coords[7*CW-1:6*CW]});
  assign y4 = $signed({coords[8*CW-1], coords[8*CW-1:7*CW]});

  // The stage takes a new item when it is empty or its content moves on.
  assign ready_up = !valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      dx12 <= x1 - x2;
      dy12 <= y1 - y2;
      dx34 <= x3 - x4;
      dy34 <= y3 - y4;
      dx13 <= x1 - x3;
      dy13 <= y1 - y3;
    end
  end

endmodule

/* rtl/core/sit_mult.sv */
// Second pipeline stage: the six cross-product terms, one multiplier each.
// Depends on sit_pkg.
module sit_mult
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  valid_in,
  output logic                                  ready_up,
  input  logic signed [COORD_WIDTH:0]           dx12,
  input  logic signed [COORD_WIDTH:0]           dy12,
  input  logic signed [COORD_WIDTH:0]           dx34,
  input  logic signed [COORD_WIDTH:0]           dy34,
  input  logic signed [COORD_WIDTH:0]           dx13,
  input  logic signed [COORD_WIDTH:0]           dy13,
  output logic                                  valid,
  input  logic                                  ready_dn,
  output logic signed [2*COORD_WIDTH+1:0]       p_d0,
  output logic signed [2*COORD_WIDTH+1:0]       p_d1,
  output logic signed [2*COORD_WIDTH+1:0]       p_t0,
  output logic signed [2*COORD_WIDTH+1:0]       p_t1,
  output logic signed [2*COORD_WIDTH+1:0]       p_u0,
  output logic signed [2*COORD_WIDTH+1:0]       p_u1
);

  localparam int PW = 2 * COORD_WIDTH + 2;

  assign ready_up = !valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  // Terms of d, tn and un; each product fits its full double width.
  // The operands are sign-extended to the product width first.
  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      p_d0 <= PW'(dx12) * PW'(dy34);
      p_d1 <= PW'(dy12) * PW'(dx34);
      p_t0 <= PW'(dx13) * PW'(dy34);
      p_t1 <= PW'(dy13) * PW'(dx34);
      p_u0 <= PW'(dy12) * PW'(dx13);
      p_u1 <= PW'(dx12) * PW'(dy13);
    end
  end

endmodule

/* rtl/core/sit_comb.sv */
// Third pipeline stage: combines the product pairs into d, tn and un.
// Depends on sit_pkg.
module sit_comb
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  valid_in,
  output logic                                  ready_up,
  input  logic signed [2*COORD_WIDTH+1:0]       p_d0,
  input  logic signed [2*COORD_WIDTH+1:0]       p_d1,
  input  logic signed [2*COORD_WIDTH+1:0]       p_t0,
  input  logic signed [2*COORD_WIDTH+1:0]       p_t1,
  input  logic signed [2*COORD_WIDTH+1:0]       p_u0,
  input  logic signed [2*COORD_WIDTH+1:0]       p_u1,
  output logic                                  valid,
  input  logic                                  ready_dn,
  output logic signed [2*COORD_WIDTH+2:0]       d,
  output logic signed [2*COORD_WIDTH+2:0]       tn,
  output logic signed [2*COORD_WIDTH+2:0]       un
);

  localparam int PW = 2 * COORD_WIDTH + 2;

  assign ready_up = !valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  // One extra bit keeps each difference exact.
  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      d  <= $signed({p_d0[PW-1], p_d0}) - $signed({p_d1[PW-1], p_d1});
      tn <= $signed({p_t0[PW-1], p_t0}) - $signed({p_t1[PW-1], p_t1});
      un <= $signed({p_u0[PW-1], p_u0}) - $signed({p_u1[PW-1], p_u1});
    end
  end

endmodule

/* rtl/core/sit_cmp.sv */
// Last pipeline stage: range tests of tn and un against d, and the output register.
// Depends on sit_pkg.
module sit_cmp
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  valid_in,
  output logic                                  ready_up,
  input  logic signed [2*COORD_WIDTH+2:0]       d,
  input  logic signed [2*COORD_WIDTH+2:0]       tn,
  input  logic signed [2*COORD_WIDTH+2:0]       un,
  output logic                                  valid,
  input  logic                                  ready_dn,
  output sit_result_t                           result
);

  localparam int SW = 2 * COORD_WIDTH + 3;

  logic        d_zero;
  logic        d_neg;
  logic        tn_zero;
  logic        un_zero;
  logic        hit_pos;
  logic        hit_neg;
  sit_result_t result_next;

  // With d positive both parameters must lie in [0, d]; with d negative the
  // whole range flips to [d, 0], which avoids negating the three values.
  always_comb begin
    d_zero  = (d == '0);
    d_neg   = d[SW-1];
    tn_zero = (tn == '0);
    un_zero = (un == '0);
    hit_pos = !tn[SW-1] && (tn <= d) && !un[SW-1] && (un <= d);
    hit_neg = (tn[SW-1] || tn_zero) && (tn >= d) && (un[SW-1] || un_zero) && (un >= d);
    result_next.parallel   = d_zero;
    result_next.intersects = !d_zero && (d_neg ? hit_neg : hit_pos);
  end

  assign ready_up = !valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      result <= result_next;
    end
  end

endmodule

/* dv/segment_intersection_test_tb.sv */
// Self-checking testbench for the segment intersection test block.
// Drives segment pairs on the input stream and checks each result transfer against an
// exact integer predictor or a typed-in expectation. Depends on sit_pkg and the RTL top.
module segment_intersection_test_tb;
  import sit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = COORD_WIDTH_DEF;
  localparam int RANDOM_PAIRS = 1380;
  localparam int DRAIN_LIMIT = 20000;
  localparam int REPORT_LIMIT = 10;

  // Codes for the typed-in expectations of the directed table.
  localparam int WANT_PREDICT = -1;
  localparam int WANT_MISS = 0;
  localparam int WANT_HIT = 1;
  localparam int WANT_PARALLEL = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // From bit 0: seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
  // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y.
  logic [8*COORD_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // From bit 0: intersects, parallel, then zero padding.
  logic [RESULT_TDATA_W-1:0] m_axis_tdata;

  int send_idle_pct = 8;
  int recv_idle_pct = 86;
  int mismatches = 0;
  sit_result_t expected_flags[$];

  segment_intersection_test #(.COORD_WIDTH(COORD_W)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Directed pairs: zeros, extremes, crossings, touches, parallel and
  // collinear lines, degenerate segments and sign-bit patterns.
  localparam int DIR_ROWS = 20;
  int dir_pts [DIR_ROWS][8] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
    '{-10, -10, 10, 10, -10, 10, 10, -10},
    '{0, 0, 10, 0, 10, 0, 10, 10},
    '{0, 0, 10, 0, 5, 0, 5, 7},
    '{0, 0, 10, 0, 11, -1, 11, 1},
    '{0, 0, 10, 10, 5, 5, 15, 15},
    '{0, 0, 10, 0, 0, 5, 10, 5},
    '{3, 3, 3, 3, 0, 0, 10, 10},
    '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
    '{32767, -32768, 32767, 32767, -32768, 32767, 32767, 32767},
    '{-32768, 0, 32767, 0, 0, -32768, 0, 32767},
    '{0, 0, 1, 1, 3, 0, 4, -1},
    '{-32768, -32768, -32767, -32768, 32767, 32767, 32767, 32766},
    '{1, 2, 3, 4, 5, 6, 7, 9},
    '{21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845},
    '{0, 0, 5, 0, 5, 0, 9, 0},
    '{0, 0, 32767, 32766, 0, 1, 32767, 32767},
    '{-1, -1, 1, 1, -1, 1, 1, -1}
  };
  int dir_want [DIR_ROWS] = '{
    WANT_PARALLEL, WANT_PARALLEL, WANT_PARALLEL, WANT_HIT, WANT_HIT,
    WANT_HIT, WANT_MISS, WANT_PARALLEL, WANT_PARALLEL, WANT_PARALLEL,
    WANT_HIT, WANT_HIT, WANT_HIT, WANT_PREDICT, WANT_PREDICT,
    WANT_PREDICT, WANT_PREDICT, WANT_PARALLEL, WANT_PREDICT, WANT_HIT
  };

  // Exact crossing test: scale the line parameters by the denominator and
  // compare against it after forcing the denominator positive.
  function automatic sit_result_t predict_crossing(input coord_t p[8]);
    longint dx12, dy12, dx34, dy34, dx13, dy13, den, tn, un;
    sit_result_t r;
    dx12 = longint'(p[0]) - longint'(p[2]);
    dy12 = longint'(p[1]) - longint'(p[3]);
    dx34 = longint'(p[4]) - longint'(p[6]);
    dy34 = longint'(p[5]) - longint'(p[7]);
    dx13 = longint'(p[0]) - longint'(p[4]);
    dy13 = longint'(p[1]) - longint'(p[5]);
    den = dx12 * dy34 - dy12 * dx34;
    tn = dx13 * dy34 - dy13 * dx34;
    un = dy12 * dx13 - dx12 * dy13;
    if (den < 0) begin
      den = -den;
      tn = -tn;
      un = -un;
    end
    r.parallel = (den == 0);
    r.intersects = (den != 0) && (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
    return r;
  endfunction

  function automatic coord_t wrap(input int v);
    return v[COORD_W-1:0];
  endfunction

  function automatic int spread(input int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  // Random pair generator. Most pairs sit in a small region so that hits, touches and near
  // misses are common; the rest cover the full range, extreme values or small values near zero.
  function automatic void make_random_pair(output coord_t p[8]);
    int v[8];
    int extremes[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    int cx, cy, r, kind, k, dx, dy, e;
    kind = $urandom_range(99);
    cx = int'($urandom_range(56000)) - 28000;
    cy = int'($urandom_range(56000)) - 28000;
    r = ($urandom_range(9) == 0) ? 500 : int'($urandom_range(1, 40));
    for (int i = 0; i < 8; i++) begin
      v[i] = ((i % 2) ? cy : cx) + spread(r);
    end
    if (kind < 20) begin
      // Full range, every bit free.
      for (int i = 0; i < 8; i++) v[i] = int'($urandom_range(65535)) - 32768;
    end else if (kind < 50) begin
      // Keep the region values as they are.
    end else if (kind < 60) begin
      // Parallel: B runs along a multiple of A's direction.
      k = $urandom_range(1) ? int'($urandom_range(1, 2)) : -int'($urandom_range(1, 2));
      v[6] = v[4] + k * (v[2] - v[0]);
      v[7] = v[5] + k * (v[3] - v[1]);
    end else if (kind < 70) begin
      // Collinear: all four points on one line.
      dx = spread(20);
      dy = spread(20);
      for (int i = 0; i < 4; i++) begin
        k = spread(5);
        v[2*i] = cx + k * dx;
        v[2*i+1] = cy + k * dy;
      end
    end else if (kind < 80) begin
      // B starts on one of A's endpoints.
      e = 2 * int'($urandom_range(1));
      v[4] = v[e];
      v[5] = v[e+1];
    end else if (kind < 85) begin
      // One segment shrinks to a point.
      e = 4 * int'($urandom_range(1));
      v[e+2] = v[e];
      v[e+3] = v[e+1];
    end else if (kind < 93) begin
      for (int i = 0; i < 8; i++) v[i] = extremes[$urandom_range(6)];
    end else begin
      for (int i = 0; i < 8; i++) v[i] = spread(3);
    end
    for (int i = 0; i < 8; i++) p[i] = wrap(v[i]);
  endfunction

  task automatic flag_mismatch(input string what, input sit_result_t want,
                               input sit_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected intersects=%0b parallel=%0b, got intersects=%0b parallel=%0b",
               $realtime, what, want.intersects, want.parallel, got.intersects, got.parallel);
    end
  endtask

  // Offer one pair, holding it until the transfer, then queue its result.
  task automatic send_pair(input coord_t p[8], input sit_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    for (int i = 0; i < 8; i++) s_axis_tdata[i*COORD_W +: COORD_W] <= p[i];
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_flags.push_back(want);
    @(negedge clk);
  endtask

  // Receiver stalls at random on every falling edge.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every result transfer with the oldest pending expectation.
  always @(posedge clk) begin : check_results
    sit_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[1:0];
      if (expected_flags.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = expected_flags.pop_front();
        if (got.intersects !== want.intersects || got.parallel !== want.parallel) begin
          flag_mismatch("flag mismatch", want, got);
        end
      end
    end
  end

  // Main sequence: reset, directed table, three random phases with different idle rates, drain.
  initial begin : run_stimulus
    coord_t p[8];
    sit_result_t want;
    int waited;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int row = 0; row < DIR_ROWS; row++) begin
      for (int i = 0; i < 8; i++) p[i] = wrap(dir_pts[row][i]);
      if (dir_want[row] == WANT_PREDICT) begin
        want = predict_crossing(p);
      end else begin
        want.intersects = (dir_want[row] == WANT_HIT);
        want.parallel = (dir_want[row] == WANT_PARALLEL);
      end
      send_pair(p, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PAIRS / 3; n++) begin
        make_random_pair(p);
        send_pair(p, predict_crossing(p));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the pipeline empty, then keep waiting for stray results.
    waited = 0;
    while (expected_flags.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_flags.size() != 0) begin
      $display("%0d results never arrived", expected_flags.size());
      mismatches += expected_flags.size();
    end

    if (mismatches == 0) begin
      $display("segment_intersection_test verification clean");
    end else begin
      $display("segment_intersection_test verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #1_000_000;
    $display("segment_intersection_test verification failed");
    $finish;
  end

endmodule
